// ===== rtl/core/slcs_pkg.sv =====
// Package with shared types and color constants for the status LED color sequencer.
package slcs_pkg;

  localparam int CfgW   = 16;
  localparam int ColorW = 24;

  localparam logic [ColorW-1:0] ColGreen  = 24'h00ff00;
  localparam logic [ColorW-1:0] ColRed    = 24'hff0000;
  localparam logic [ColorW-1:0] ColBlue   = 24'h0000ff;
  localparam logic [ColorW-1:0] ColYellow = 24'hffff00;
  localparam logic [ColorW-1:0] ColOrange = 24'hff8000;

  localparam logic [CfgW-1:0] FastHalfReset = 16'd200;
  localparam logic [CfgW-1:0] SlowHalfReset = 16'd1250;
  localparam logic [CfgW-1:0] FlashMsReset  = 16'd50;

  typedef enum logic [2:0] {
    MODE_TICK       = 3'd0,
    MODE_LINK_UP    = 3'd1,
    MODE_LINK_DOWN  = 3'd2,
    MODE_SET_ALERT  = 3'd3,
    MODE_TX_FLASH   = 3'd4,
    MODE_RX_FLASH   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    LINK_DOWN  = 2'd0,
    LINK_UP    = 2'd1,
    LINK_ALERT = 2'd2
  } link_t;

  typedef enum logic [1:0] {
    ALERT_NONE = 2'd0,
    ALERT_FAST = 2'd1,
    ALERT_SLOW = 2'd2
  } alert_t;

  typedef enum logic [1:0] {
    CFG_FAST_HALF = 2'd0,
    CFG_SLOW_HALF = 2'd1,
    CFG_FLASH_MS  = 2'd2
  } cfg_idx_t;

endpackage

// ===== rtl/core/status_led_color_sequencer.sv =====
// Status LED color sequencer: event-driven LED color state with registered result.
// The result beat of an accepted input beat is registered and appears in the next cycle.
// Throughput: one beat per cycle while out_tready is high; the output register frees as its beat is taken.
// The state update and color choice are one pass of logic before the state registers.
// Reset (rst_n low, synchronous): link down, no alert, no flash, counters zero,
// color red, registers at 200/1250/50, no result pending.
module status_led_color_sequencer
  import slcs_pkg::*;
#(
  parameter int COUNTER_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [1:0] alert_kind, rest zero
  input  logic [2:0]        in_tuser,   // [2:0] mode
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [ColorW-1:0] out_tdata,  // [23:0] color
  output logic              out_tuser,  // [0] color_written
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [CfgW-1:0]   cfg_data
);

  localparam int CmpW = (COUNTER_BITS > CfgW) ? COUNTER_BITS : CfgW;

  logic [CfgW-1:0]         fast_half_r, slow_half_r, flash_ms_r;
  link_t                   link_r, link_nxt;
  alert_t                  alert_r, alert_nxt;
  logic                    flash_r, flash_nxt;
  logic                    orange_r, orange_nxt;
  logic [COUNTER_BITS-1:0] blink_r, blink_nxt, blink_inc;
  logic [COUNTER_BITS-1:0] felap_r, felap_nxt, felap_inc;
  logic [ColorW-1:0]       shown_r, shown_nxt;
  logic                    wrote;
  logic                    out_valid_r;
  logic [ColorW-1:0]       out_color_r;
  logic                    out_wr_r;
  logic                    accept;
  logic [1:0]              kind;
  logic [CfgW-1:0]         period;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_color_r;
  assign out_tuser  = out_wr_r;
  assign kind       = in_tdata[1:0];

  assign blink_inc = (&blink_r) ? blink_r : blink_r + 1'b1;
  assign felap_inc = (&felap_r) ? felap_r : felap_r + 1'b1;
  assign period    = (alert_r == ALERT_FAST) ? fast_half_r : slow_half_r;

  always_comb begin
    link_nxt   = link_r;
    alert_nxt  = alert_r;
    flash_nxt  = flash_r;
    orange_nxt = orange_r;
    blink_nxt  = blink_r;
    felap_nxt  = felap_r;
    shown_nxt  = shown_r;
    wrote      = 1'b0;
    unique case (mode_t'(in_tuser))
      MODE_TICK: begin
        blink_nxt = blink_inc;
        felap_nxt = felap_inc;
        if (alert_r != ALERT_NONE) begin
          if (CmpW'(blink_inc) >= CmpW'(period)) begin
            blink_nxt  = '0;
            orange_nxt = !orange_r;
            shown_nxt  = orange_r ? ColGreen : ColOrange;
            wrote      = 1'b1;
          end
        end else if (flash_r && (CmpW'(felap_inc) > CmpW'(flash_ms_r))) begin
          flash_nxt = 1'b0;
          wrote     = 1'b1;
          if (link_r == LINK_UP) begin
            shown_nxt = ColGreen;
          end else begin
            link_nxt  = LINK_DOWN;
            shown_nxt = ColRed;
          end
        end
      end
      MODE_LINK_UP: begin
        link_nxt = LINK_UP;
        if (alert_r == ALERT_NONE && !flash_r) begin
          shown_nxt = ColGreen;
          wrote     = 1'b1;
        end
      end
      MODE_LINK_DOWN: begin
        link_nxt  = LINK_DOWN;
        alert_nxt = ALERT_NONE;
        if (!flash_r) begin
          shown_nxt = ColRed;
          wrote     = 1'b1;
        end
      end
      MODE_SET_ALERT: begin
        if (kind != 2'd3 && kind != alert_r) begin
          alert_nxt = alert_t'(kind);
          if (kind != ALERT_NONE) begin
            link_nxt   = LINK_ALERT;
            blink_nxt  = '0;
            orange_nxt = 1'b0;
            shown_nxt  = ColGreen;
            wrote      = 1'b1;
          end else if (link_r == LINK_ALERT || link_r == LINK_UP) begin
            link_nxt = LINK_UP;
            if (!flash_r) begin
              shown_nxt = ColGreen;
              wrote     = 1'b1;
            end
          end
        end
      end
      MODE_TX_FLASH, MODE_RX_FLASH: begin
        if (alert_r == ALERT_NONE && !flash_r) begin
          flash_nxt = 1'b1;
          felap_nxt = '0;
          shown_nxt = (in_tuser == MODE_TX_FLASH) ? ColBlue : ColYellow;
          wrote     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_half_r <= FastHalfReset;
      slow_half_r <= SlowHalfReset;
      flash_ms_r  <= FlashMsReset;
      link_r      <= LINK_DOWN;
      alert_r     <= ALERT_NONE;
      flash_r     <= 1'b0;
      orange_r    <= 1'b0;
      blink_r     <= '0;
      felap_r     <= '0;
      shown_r     <= ColRed;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_FAST_HALF: fast_half_r <= cfg_data;
          CFG_SLOW_HALF: slow_half_r <= cfg_data;
          CFG_FLASH_MS:  flash_ms_r  <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        link_r      <= link_nxt;
        alert_r     <= alert_nxt;
        flash_r     <= flash_nxt;
        orange_r    <= orange_nxt;
        blink_r     <= blink_nxt;
        felap_r     <= felap_nxt;
        shown_r     <= shown_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_color_r <= shown_nxt;
      out_wr_r    <= wrote;
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid)
    else $error("accepted beat produced no result");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_tdata == shown_r))
    else $error("result color differs from shown color");

  a_palette: assert property (@(posedge clk) disable iff (!rst_n)
    (shown_r == ColRed) || (shown_r == ColGreen) || (shown_r == ColBlue) ||
    (shown_r == ColYellow) || (shown_r == ColOrange))
    else $error("shown color outside palette");

  a_bad_mode_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_tuser == 3'd6 || in_tuser == 3'd7)) |=>
      (!out_tuser && $stable(shown_r)))
    else $error("unused mode changed the color");

  a_flash_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && flash_r && (in_tuser == MODE_TX_FLASH || in_tuser == MODE_RX_FLASH)) |=>
      !out_tuser)
    else $error("flash restarted during flash");

endmodule
